// File: sv/iie_pkg.sv
// ----------------------------------------------------------------------------
// iie_pkg: shared types and constants of the integer instruction executor
// Operation codes, register-write targets, the packed layouts of the input
// and result transfers, and the sizes of the register files and data memory.
// ----------------------------------------------------------------------------
package iie_pkg;

  // Data path and register file geometry.
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned REG_COUNT     = 32;
  localparam int unsigned REG_AW        = 5;
  localparam int unsigned IMM_W         = 16;
  localparam int unsigned STORE_ADDR_W  = 16;
  localparam int unsigned MEM_WORDS_DEF = 65536;

  // Transfer widths, rounded up to whole bytes.
  localparam int unsigned IN_W  = 104;
  localparam int unsigned OUT_W = 88;

  // Link register written by jal.
  localparam logic [REG_AW-1:0] LINK_REG = 5'd31;

  // Region bits kept from the incremented program counter on a jump.
  localparam logic [DATA_W-1:0] JUMP_REGION_MASK = 32'hF000_0000;

  // Operation codes; codes above FN_SWC1 have no effect.
  typedef enum logic [4:0] {
    FN_ADD  = 5'd0,
    FN_SUB  = 5'd1,
    FN_JR   = 5'd2,
    FN_SLT  = 5'd3,
    FN_SLL  = 5'd4,
    FN_SRL  = 5'd5,
    FN_ADDI = 5'd6,
    FN_LUI  = 5'd7,
    FN_ORI  = 5'd8,
    FN_SLTI = 5'd9,
    FN_BNE  = 5'd10,
    FN_BEQ  = 5'd11,
    FN_LW   = 5'd12,
    FN_SW   = 5'd13,
    FN_J    = 5'd14,
    FN_JAL  = 5'd15,
    FN_MTC1 = 5'd16,
    FN_FORI = 5'd17,
    FN_FLUI = 5'd18,
    FN_LWC1 = 5'd19,
    FN_SWC1 = 5'd20
  } func_t;

  // Register file that a result writes.
  typedef enum logic [1:0] {
    WT_NONE  = 2'd0,
    WT_INT   = 2'd1,
    WT_FLOAT = 2'd2
  } wtarget_t;

  // Input transfer layout, last field in the lowest bits.
  typedef struct packed {
    logic [4:0]          pad;
    logic [DATA_W-1:0]   pc_now;
    logic [25:0]         jump_target;
    logic [IMM_W-1:0]    immediate;
    logic [4:0]          shift_amount;
    logic [REG_AW-1:0]   dest_index;
    logic [REG_AW-1:0]   second_index;
    logic [REG_AW-1:0]   src_index;
    logic [4:0]          func;
  } in_item_t;

  // Result transfer layout, last field in the lowest bits.
  typedef struct packed {
    logic [STORE_ADDR_W-1:0] store_address;
    logic                    store_done;
    logic [DATA_W-1:0]       write_value;
    logic [REG_AW-1:0]       write_index;
    wtarget_t                write_target;
    logic [DATA_W-1:0]       next_pc;
  } res_item_t;

endpackage

// File: sv/iie_ram.sv
// ----------------------------------------------------------------------------
// iie_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and only
// updated when the read enable is high.
// ----------------------------------------------------------------------------
module iie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a read and a write of one entry in the same cycle
  // return the old contents.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/iie_regfile.sv
// ----------------------------------------------------------------------------
// iie_regfile: 32-entry register file with two read ports
// Two RAM copies written together give two read ports. A valid bit per
// entry makes a register that was never written read as zero after reset.
// ----------------------------------------------------------------------------
module iie_regfile (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             rd_en,
  input  logic [iie_pkg::REG_AW-1:0]       rd_addr_a,
  input  logic [iie_pkg::REG_AW-1:0]       rd_addr_b,
  output logic [iie_pkg::DATA_W-1:0]       rd_data_a,
  output logic [iie_pkg::DATA_W-1:0]       rd_data_b,
  input  logic                             wr_en,
  input  logic [iie_pkg::REG_AW-1:0]       wr_addr,
  input  logic [iie_pkg::DATA_W-1:0]       wr_data
);

  logic [iie_pkg::REG_COUNT-1:0] valid_r;
  logic [iie_pkg::REG_COUNT-1:0] valid_nxt;
  logic                          ok_a_r;
  logic                          ok_b_r;
  logic [iie_pkg::DATA_W-1:0]    ram_a;
  logic [iie_pkg::DATA_W-1:0]    ram_b;

  iie_ram #(
    .WIDTH (iie_pkg::DATA_W),
    .DEPTH (iie_pkg::REG_COUNT)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_a),
    .rd_data (ram_a)
  );

  iie_ram #(
    .WIDTH (iie_pkg::DATA_W),
    .DEPTH (iie_pkg::REG_COUNT)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_b),
    .rd_data (ram_b)
  );

  // Mark an entry written.
  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  // Valid bits are sampled with the read, before this cycle's write, to
  // match the read-before-write behavior of the RAM.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ok_a_r  <= 1'b0;
      ok_b_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (rd_en) begin
        ok_a_r <= valid_r[rd_addr_a];
        ok_b_r <= valid_r[rd_addr_b];
      end
    end
  end

  assign rd_data_a = ok_a_r ? ram_a : '0;
  assign rd_data_b = ok_b_r ? ram_b : '0;

endmodule

// File: sv/iie_dmem.sv
// ----------------------------------------------------------------------------
// iie_dmem: word-addressed data memory with a clearing pass
// After reset the memory is swept to zero one word per cycle; clear_done
// rises when the sweep has finished. MEM_WORDS is a power of two.
// ----------------------------------------------------------------------------
module iie_dmem #(
  parameter int unsigned MEM_WORDS = iie_pkg::MEM_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [$clog2(MEM_WORDS)-1:0] wr_addr,
  input  logic [iie_pkg::DATA_W-1:0]   wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(MEM_WORDS)-1:0] rd_addr,
  output logic [iie_pkg::DATA_W-1:0]   rd_data,
  output logic                         clear_done
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

  logic [AW-1:0]              clr_cnt_r;
  logic [AW-1:0]              clr_cnt_nxt;
  logic                       clr_done_r;
  logic                       clr_done_nxt;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [iie_pkg::DATA_W-1:0] ram_wdata;

  // Sweep counter.
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_done_nxt = clr_done_r;
    if (!clr_done_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == LAST_ADDR) begin
        clr_done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_done_r <= clr_done_nxt;
    end
  end

  // The sweep owns the write port until it is done.
  assign ram_we    = clr_done_r ? wr_en   : 1'b1;
  assign ram_waddr = clr_done_r ? wr_addr : clr_cnt_r;
  assign ram_wdata = clr_done_r ? wr_data : '0;

  iie_ram #(
    .WIDTH (iie_pkg::DATA_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign clear_done = clr_done_r;

endmodule

// File: sv/integer_instruction_execute.sv
// ----------------------------------------------------------------------------
// integer_instruction_execute: decoded integer instruction executor
// Executes one decoded instruction per transfer against an integer register
// file, a float-bit register file and a word-addressed data memory.
//
// Usage:
//   The in_ channel carries one decoded instruction and its program counter.
//   The out_ channel returns one result per instruction, in order: the next
//   program counter, any register write and any store.
//   Stages: register read, execute with data memory access, result register.
//   Throughput: one instruction per cycle while the pipeline is not stalled;
//   dependent instructions issue back to back through forwarding from the
//   result stage and the last write.
//   Reset: all registers and memory read as zero. The data memory is swept
//   to zero one word per cycle, all MEM_WORDS words (65536 by default), and
//   in_tready stays low until the sweep completes.
//   Stall: a two-entry output (result register plus skid register) keeps
//   taking input after out_tready drops until the skid fills; then in_tready
//   falls and the whole pipeline holds until the skid register drains.
//   MEM_WORDS must be a power of two; addresses wrap to the memory size.
// ----------------------------------------------------------------------------
module integer_instruction_execute #(
  parameter int unsigned MEM_WORDS = iie_pkg::MEM_WORDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Fields from bit 0: func(5), src_index(5), second_index(5), dest_index(5),
  // shift_amount(5), immediate(16), jump_target(26), pc_now(32), zero pad(5).
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [iie_pkg::IN_W-1:0]  in_tdata,
  // Fields from bit 0: next_pc(32), write_target(2), write_index(5),
  // write_value(32), store_done(1), store_address(16).
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [iie_pkg::OUT_W-1:0] out_tdata
);

  localparam int unsigned MEM_AW = $clog2(MEM_WORDS);

  typedef logic [iie_pkg::DATA_W-1:0] word_t;

  // Pick the newest value of a register: the result stage first, then the
  // last write (missed by a read in the same cycle), then the file.
  function automatic word_t fwd(
    input logic [iie_pkg::REG_AW-1:0] idx,
    input iie_pkg::wtarget_t          tgt,
    input word_t                      file_val,
    input logic                       m_valid,
    input iie_pkg::wtarget_t          m_tgt,
    input logic [iie_pkg::REG_AW-1:0] m_idx,
    input word_t                      m_val,
    input iie_pkg::wtarget_t          w_tgt,
    input logic [iie_pkg::REG_AW-1:0] w_idx,
    input word_t                      w_val
  );
    word_t v;
    v = file_val;
    if (w_tgt == tgt && w_idx == idx) begin
      v = w_val;
    end
    if (m_valid && m_tgt == tgt && m_idx == idx) begin
      v = m_val;
    end
    return v;
  endfunction

  // Pipeline control.
  logic advance;
  logic in_acc;
  logic clear_done;
  logic ex_valid_r;
  logic mem_valid_r;
  logic mem_go;

  // Execute stage.
  iie_pkg::in_item_t  in_item;
  iie_pkg::in_item_t  ex_item_r;
  iie_pkg::func_t     ex_fn;
  iie_pkg::res_item_t ex_res;
  logic               ex_load;
  logic               ex_store;
  logic [MEM_AW-1:0]  ex_addr;
  word_t              ex_sdata;
  word_t              op_a;
  word_t              op_b;
  word_t              op_fa;
  word_t              op_fb;
  word_t              int_a_q;
  word_t              int_b_q;
  word_t              flt_a_q;
  word_t              flt_b_q;
  word_t              simm;
  word_t              zimm;
  word_t              addr_sum;
  word_t              pc_inc;
  word_t              jump_pc;

  // Result stage.
  iie_pkg::res_item_t mem_res_r;
  iie_pkg::res_item_t mem_res;
  logic               mem_load_r;
  word_t              dmem_q;

  // Last register write.
  iie_pkg::wtarget_t           wb_wt_r;
  logic [iie_pkg::REG_AW-1:0]  wb_wi_r;
  word_t                       wb_wv_r;

  // Output register and skid register.
  logic               out_valid_r;
  logic               skid_valid_r;
  iie_pkg::res_item_t out_data_r;
  iie_pkg::res_item_t skid_data_r;

  // The pipeline moves as one while the skid register is empty.
  assign advance   = !skid_valid_r;
  assign in_tready = advance && clear_done;
  assign in_acc    = in_tvalid && in_tready;
  assign mem_go    = advance && mem_valid_r;
  assign in_item   = iie_pkg::in_item_t'(in_tdata);

  // Register files are read at the input transfer.
  iie_regfile u_int_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (advance),
    .rd_addr_a (in_item.src_index),
    .rd_addr_b (in_item.second_index),
    .rd_data_a (int_a_q),
    .rd_data_b (int_b_q),
    .wr_en     (mem_go && mem_res.write_target == iie_pkg::WT_INT),
    .wr_addr   (mem_res.write_index),
    .wr_data   (mem_res.write_value)
  );

  iie_regfile u_flt_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (advance),
    .rd_addr_a (in_item.src_index),
    .rd_addr_b (in_item.second_index),
    .rd_data_a (flt_a_q),
    .rd_data_b (flt_b_q),
    .wr_en     (mem_go && mem_res.write_target == iie_pkg::WT_FLOAT),
    .wr_addr   (mem_res.write_index),
    .wr_data   (mem_res.write_value)
  );

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      mem_valid_r <= 1'b0;
    end else if (advance) begin
      ex_valid_r  <= in_acc;
      mem_valid_r <= ex_valid_r;
    end
  end

  // Execute stage payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      ex_item_r <= in_item;
    end
  end

  // Forwarded operands.
  always_comb begin
    op_a  = fwd(ex_item_r.src_index, iie_pkg::WT_INT, int_a_q,
                mem_valid_r, mem_res_r.write_target, mem_res_r.write_index,
                mem_res.write_value, wb_wt_r, wb_wi_r, wb_wv_r);
    op_b  = fwd(ex_item_r.second_index, iie_pkg::WT_INT, int_b_q,
                mem_valid_r, mem_res_r.write_target, mem_res_r.write_index,
                mem_res.write_value, wb_wt_r, wb_wi_r, wb_wv_r);
    op_fa = fwd(ex_item_r.src_index, iie_pkg::WT_FLOAT, flt_a_q,
                mem_valid_r, mem_res_r.write_target, mem_res_r.write_index,
                mem_res.write_value, wb_wt_r, wb_wi_r, wb_wv_r);
    op_fb = fwd(ex_item_r.second_index, iie_pkg::WT_FLOAT, flt_b_q,
                mem_valid_r, mem_res_r.write_target, mem_res_r.write_index,
                mem_res.write_value, wb_wt_r, wb_wi_r, wb_wv_r);
  end

  // Execute: ALU, compare, branch target and memory address.
  always_comb begin
    ex_fn    = iie_pkg::func_t'(ex_item_r.func);
    simm     = {{(iie_pkg::DATA_W - iie_pkg::IMM_W){ex_item_r.immediate[iie_pkg::IMM_W-1]}},
                ex_item_r.immediate};
    zimm     = {{(iie_pkg::DATA_W - iie_pkg::IMM_W){1'b0}}, ex_item_r.immediate};
    addr_sum = op_a + simm;
    ex_addr  = addr_sum[MEM_AW-1:0];
    pc_inc   = ex_item_r.pc_now + word_t'(1);
    jump_pc  = (pc_inc & iie_pkg::JUMP_REGION_MASK) |
               word_t'(ex_item_r.jump_target);
    ex_sdata = op_b;
    ex_load  = 1'b0;
    ex_store = 1'b0;

    ex_res              = '0;
    ex_res.next_pc      = ex_item_r.pc_now;
    ex_res.write_target = iie_pkg::WT_NONE;

    case (ex_fn)
      iie_pkg::FN_ADD: begin
        ex_res.write_target = iie_pkg::WT_INT;
        ex_res.write_index  = ex_item_r.dest_index;
        ex_res.write_value  = op_a + op_b;
      end
      iie_pkg::FN_SUB: begin
        ex_res.write_target = iie_pkg::WT_INT;
        ex_res.write_index  = ex_item_r.dest_index;
        ex_res.write_value  = op_a - op_b;
      end
      iie_pkg::FN_JR: begin
        ex_res.next_pc = op_a;
      end
      iie_pkg::FN_SLT: begin
        ex_res.write_target = iie_pkg::WT_INT;
        ex_res.write_index  = ex_item_r.dest_index;
        ex_res.write_value  = word_t'($signed(op_a) < $signed(op_b));
      end
      iie_pkg::FN_SLL: begin
        ex_res.write_target = iie_pkg::WT_INT;
        ex_res.write_index  = ex_item_r.dest_index;
        ex_res.write_value  = op_b << ex_item_r.shift_amount;
      end
      iie_pkg::FN_SRL: begin
        ex_res.write_target = iie_pkg::WT_INT;
        ex_res.write_index  = ex_item_r.dest_index;
        ex_res.write_value  = op_b >> ex_item_r.shift_amount;
      end
      iie_pkg::FN_ADDI: begin
        ex_res.write_target = iie_pkg::WT_INT;
        ex_res.write_index  = ex_item_r.second_index;
        ex_res.write_value  = addr_sum;
      end
      iie_pkg::FN_LUI: begin
        ex_res.write_target = iie_pkg::WT_INT;
        ex_res.write_index  = ex_item_r.second_index;
        ex_res.write_value  = {ex_item_r.immediate, {iie_pkg::IMM_W{1'b0}}};
      end
      iie_pkg::FN_ORI: begin
        ex_res.write_target = iie_pkg::WT_INT;
        ex_res.write_index  = ex_item_r.second_index;
        ex_res.write_value  = op_a | zimm;
      end
      iie_pkg::FN_SLTI: begin
        ex_res.write_target = iie_pkg::WT_INT;
        ex_res.write_index  = ex_item_r.second_index;
        ex_res.write_value  = word_t'($signed(op_a) < $signed(simm));
      end
      iie_pkg::FN_BNE: begin
        if (op_a != op_b) begin
          ex_res.next_pc = ex_item_r.pc_now + simm;
        end
      end
      iie_pkg::FN_BEQ: begin
        if (op_a == op_b) begin
          ex_res.next_pc = ex_item_r.pc_now + simm;
        end
      end
      iie_pkg::FN_LW: begin
        ex_load             = 1'b1;
        ex_res.write_target = iie_pkg::WT_INT;
        ex_res.write_index  = ex_item_r.second_index;
      end
      iie_pkg::FN_SW: begin
        ex_store             = 1'b1;
        ex_res.store_done    = 1'b1;
        ex_res.store_address = iie_pkg::STORE_ADDR_W'(ex_addr);
      end
      iie_pkg::FN_J: begin
        ex_res.next_pc = jump_pc;
      end
      iie_pkg::FN_JAL: begin
        ex_res.next_pc      = jump_pc;
        ex_res.write_target = iie_pkg::WT_INT;
        ex_res.write_index  = iie_pkg::LINK_REG;
        ex_res.write_value  = pc_inc;
      end
      iie_pkg::FN_MTC1: begin
        ex_res.write_target = iie_pkg::WT_FLOAT;
        ex_res.write_index  = ex_item_r.second_index;
        ex_res.write_value  = op_a;
      end
      iie_pkg::FN_FORI: begin
        ex_res.write_target = iie_pkg::WT_FLOAT;
        ex_res.write_index  = ex_item_r.second_index;
        ex_res.write_value  = op_fa | zimm;
      end
      iie_pkg::FN_FLUI: begin
        ex_res.write_target = iie_pkg::WT_FLOAT;
        ex_res.write_index  = ex_item_r.second_index;
        ex_res.write_value  = {ex_item_r.immediate, {iie_pkg::IMM_W{1'b0}}};
      end
      iie_pkg::FN_LWC1: begin
        ex_load             = 1'b1;
        ex_res.write_target = iie_pkg::WT_FLOAT;
        ex_res.write_index  = ex_item_r.second_index;
      end
      iie_pkg::FN_SWC1: begin
        ex_store             = 1'b1;
        ex_sdata             = op_fb;
        ex_res.store_done    = 1'b1;
        ex_res.store_address = iie_pkg::STORE_ADDR_W'(ex_addr);
      end
      default: begin
        // Undefined operation: no effect.
      end
    endcase
  end

  // Data memory: stores write and loads read as the item leaves execute.
  iie_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (advance && ex_valid_r && ex_store),
    .wr_addr    (ex_addr),
    .wr_data    (ex_sdata),
    .rd_en      (advance),
    .rd_addr    (ex_addr),
    .rd_data    (dmem_q),
    .clear_done (clear_done)
  );

  // Result stage payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      mem_res_r  <= ex_res;
      mem_load_r <= ex_load;
    end
  end

  // Loads take their value from the memory read.
  always_comb begin
    mem_res = mem_res_r;
    if (mem_load_r) begin
      mem_res.write_value = dmem_q;
    end
  end

  // Remember the last register write for forwarding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_wt_r <= iie_pkg::WT_NONE;
    end else if (mem_go && mem_res.write_target != iie_pkg::WT_NONE) begin
      wb_wt_r <= mem_res.write_target;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_go && mem_res.write_target != iie_pkg::WT_NONE) begin
      wb_wi_r <= mem_res.write_index;
      wb_wv_r <= mem_res.write_value;
    end
  end

  // Output and skid control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (out_valid_r && !out_tready) begin
      if (mem_valid_r) begin
        skid_valid_r <= 1'b1;
      end
    end else begin
      out_valid_r <= mem_valid_r;
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
      end
    end else if (out_valid_r && !out_tready) begin
      skid_data_r <= mem_res;
    end else begin
      out_data_r <= mem_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sv/iie_checker.sv
// ----------------------------------------------------------------------------
// iie_checker: port-level checks of the instruction executor
// Watches the transfers on both channels, the reset sweep and the zeroing
// of unused result fields.
// ----------------------------------------------------------------------------
module iie_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [iie_pkg::OUT_W-1:0] out_tdata
);

  logic [2:0] pending_r;
  logic [2:0] pending_nxt;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  // Instructions taken but not yet returned.
  always_comb begin
    pending_nxt = pending_r;
    if (in_xfer && !out_xfer) begin
      pending_nxt = pending_r + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_nxt = pending_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // No result without an instruction to answer.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != 3'd0)
    else $error("result without a pending instruction");

  // At most four instructions in flight: execute, result, output, skid.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd4)
    else $error("too many instructions in flight");

  // The memory sweep blocks input right after reset.
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted during the memory sweep");

  // A result without a register write carries zero index and value.
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] == iie_pkg::WT_NONE |-> out_tdata[70:34] == '0)
    else $error("register fields set without a register write");

endmodule

bind integer_instruction_execute iie_checker u_iie_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
